// ----- design/tilt_pkg.sv -----
`default_nettype none

package tilt_pkg;

    // sample and coefficient geometry
    localparam int SAMPLE_WIDTH  = 16;
    localparam int COEFF_W       = 16;
    localparam int FRAC_BITS     = 14;
    localparam int ROUND_HALF    = 1 << (FRAC_BITS - 1);
    localparam int NUM_AXES      = 3;
    localparam int AXIS_X        = 0;
    localparam int AXIS_Y        = 1;
    localparam int AXIS_Z        = 2;

    // configuration port
    localparam int REG_W         = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_Z = 2'd2;
    localparam logic [REG_W-1:0] ROW_RESET [NUM_AXES] = '{
        64'h0000_0000_0000_4000,
        64'h0000_0000_4000_0000,
        64'h0000_4000_0000_0000
    };

    // magnitude and square root
    localparam int SQ_W          = 2 * SAMPLE_WIDTH - 1;
    localparam int MAG_W         = 2 * SAMPLE_WIDTH;
    localparam int RAD_SHIFT     = 16;
    localparam int RAD_W         = MAG_W + RAD_SHIFT;
    localparam int ROOT_W        = RAD_W / 2;
    localparam int REM_W         = ROOT_W + 2;

    // angle datapath
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int CORDIC_W      = ROOT_W + 3;
    localparam int ANGLE_W       = 25;
    localparam int ATAN_W        = 23;
    localparam int ANGLE_FRAC    = 16;
    localparam int TILT_FRAC     = 8;
    localparam int Y_SCALE       = TILT_FRAC;
    localparam int TILT_W        = 16;
    localparam int DEG90_Q16     = 90 * (1 << ANGLE_FRAC);
    localparam int TILT_ROUND    = 1 << (ANGLE_FRAC - TILT_FRAC - 1);
    localparam logic [TILT_W-1:0] TILT_MAX = TILT_W'(180 * (1 << TILT_FRAC));
    localparam logic [TILT_W-1:0] TILT_MID = TILT_W'(90 * (1 << TILT_FRAC));

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [MAX_STAGES] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] cal_x;
        logic signed [SAMPLE_WIDTH-1:0] cal_y;
        logic signed [SAMPLE_WIDTH-1:0] cal_z;
        logic        [TILT_W-1:0]       tilt_deg;
    } result_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] cal_x;
        logic signed [SAMPLE_WIDTH-1:0] cal_y;
        logic signed [SAMPLE_WIDTH-1:0] cal_z;
    } cal_vec_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] offset;
        logic signed [COEFF_W-1:0] gain_z;
        logic signed [COEFF_W-1:0] gain_y;
        logic signed [COEFF_W-1:0] gain_x;
    } coeff_row_t;

endpackage

`default_nettype wire

// ----- design/tilt_calib.sv -----
`default_nettype none

module tilt_calib (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  tilt_pkg::sample_t    in_sample,
    input  tilt_pkg::coeff_row_t rows [tilt_pkg::NUM_AXES],
    output logic                 out_valid,
    output tilt_pkg::cal_vec_t   out_cal
);

    localparam int SW       = tilt_pkg::SAMPLE_WIDTH;
    localparam int NA       = tilt_pkg::NUM_AXES;
    localparam int PROD_W   = tilt_pkg::COEFF_W + SW;
    localparam int SUM_W    = PROD_W + 2;
    localparam int SCALED_W = SUM_W - tilt_pkg::FRAC_BITS;
    localparam int ADJ_W    = SCALED_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(tilt_pkg::ROUND_HALF);
    localparam logic signed [ADJ_W-1:0] SAT_HI   = ADJ_W'((1 << (SW - 1)) - 1);
    localparam logic signed [ADJ_W-1:0] SAT_LO   = ADJ_W'(-(1 << (SW - 1)));

    logic signed [SW-1:0]                axis      [NA];
    logic signed [tilt_pkg::COEFF_W-1:0] gain      [NA][NA];
    logic signed [PROD_W-1:0]            prod_next [NA][NA];
    logic signed [PROD_W-1:0]            prod_reg  [NA][NA];
    logic                                valid_a_reg;
    logic signed [SUM_W-1:0]             sum       [NA];
    logic signed [SUM_W-1:0]             rounded   [NA];
    logic signed [SCALED_W-1:0]          scaled    [NA];
    logic signed [ADJ_W-1:0]             adj       [NA];
    logic signed [SW-1:0]                cal_next  [NA];
    logic signed [SW-1:0]                cal_reg   [NA];
    logic                                valid_b_reg;

    // stage a: nine gain products
    always_comb
    begin
        axis[tilt_pkg::AXIS_X] = in_sample.accel_x;
        axis[tilt_pkg::AXIS_Y] = in_sample.accel_y;
        axis[tilt_pkg::AXIS_Z] = in_sample.accel_z;
        for (int r = 0; r < NA; r++)
        begin
            gain[r][tilt_pkg::AXIS_X] = rows[r].gain_x;
            gain[r][tilt_pkg::AXIS_Y] = rows[r].gain_y;
            gain[r][tilt_pkg::AXIS_Z] = rows[r].gain_z;
        end
        for (int r = 0; r < NA; r++)
        begin
            for (int c = 0; c < NA; c++)
            begin
                prod_next[r][c] = gain[r][c] * axis[c];
            end
        end
    end

    // stage b: sum, round half up, add offset, saturate
    always_comb
    begin
        for (int r = 0; r < NA; r++)
        begin
            sum[r]     = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                       + SUM_W'(prod_reg[r][2]);
            rounded[r] = sum[r] + HALF_LSB;
            scaled[r]  = rounded[r][SUM_W-1:tilt_pkg::FRAC_BITS];
            adj[r]     = ADJ_W'(scaled[r]) + ADJ_W'(rows[r].offset);
            if (adj[r] > SAT_HI)
            begin
                cal_next[r] = SAT_HI[SW-1:0];
            end
            else if (adj[r] < SAT_LO)
            begin
                cal_next[r] = SAT_LO[SW-1:0];
            end
            else
            begin
                cal_next[r] = adj[r][SW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            cal_reg  <= cal_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid     = valid_b_reg;
    assign out_cal.cal_x = cal_reg[tilt_pkg::AXIS_X];
    assign out_cal.cal_y = cal_reg[tilt_pkg::AXIS_Y];
    assign out_cal.cal_z = cal_reg[tilt_pkg::AXIS_Z];

endmodule

`default_nettype wire

// ----- design/tilt_mag.sv -----
`default_nettype none

module tilt_mag (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  tilt_pkg::cal_vec_t            in_cal,
    output logic                          out_valid,
    output tilt_pkg::cal_vec_t            out_cal,
    output logic [tilt_pkg::ROOT_W-1:0]   out_root,
    output logic                          out_zero
);

    localparam int SW     = tilt_pkg::SAMPLE_WIDTH;
    localparam int SQ_W   = tilt_pkg::SQ_W;
    localparam int MAG_W  = tilt_pkg::MAG_W;
    localparam int RAD_W  = tilt_pkg::RAD_W;
    localparam int ROOT_W = tilt_pkg::ROOT_W;
    localparam int REM_W  = tilt_pkg::REM_W;
    localparam int ACC_W  = REM_W + 2;

    logic signed [2*SW-1:0] sq_y_full;
    logic signed [2*SW-1:0] sq_z_full;
    logic [SQ_W-1:0]        sq_y_reg;
    logic [SQ_W-1:0]        sq_z_reg;
    tilt_pkg::cal_vec_t     cal_m1_reg;
    logic                   valid_m1_reg;
    logic [MAG_W-1:0]       mag;

    // index 0 is the radicand register, 1..ROOT_W one root bit each
    logic [RAD_W-1:0]       rad_reg   [0:ROOT_W-1];
    logic [REM_W-1:0]       rem_reg   [1:ROOT_W];
    logic [ROOT_W-1:0]      root_reg  [1:ROOT_W];
    tilt_pkg::cal_vec_t     cal_reg   [0:ROOT_W];
    logic                   zero_reg  [0:ROOT_W];
    logic                   valid_reg [0:ROOT_W];

    // squares of y and z
    always_comb
    begin
        sq_y_full = in_cal.cal_y * in_cal.cal_y;
        sq_z_full = in_cal.cal_z * in_cal.cal_z;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_y_reg   <= sq_y_full[SQ_W-1:0];
            sq_z_reg   <= sq_z_full[SQ_W-1:0];
            cal_m1_reg <= in_cal;
        end
    end

    // y^2 + z^2; the radicand register below scales it by 2^16
    assign mag = MAG_W'(sq_y_reg) + MAG_W'(sq_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[0]  <= {mag, {tilt_pkg::RAD_SHIFT{1'b0}}};
            zero_reg[0] <= (mag == '0);
            cal_reg[0]  <= cal_m1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m1_reg <= 1'b0;
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_m1_reg <= in_valid;
            valid_reg[0] <= valid_m1_reg;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [ACC_W-1:0]  acc;
        logic [ACC_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 1)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        always_comb
        begin
            acc   = {rem_prev, rad_reg[k-1][RAD_W-1 -: 2]};
            trial = ACC_W'({root_prev, 2'b01});
            if (acc >= trial)
            begin
                rem_next  = REM_W'(acc - trial);
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = acc[REM_W-1:0];
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                cal_reg[k]  <= cal_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end

        if (k < ROOT_W)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[k] <= {rad_reg[k-1][RAD_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_cal   = cal_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_zero  = zero_reg[ROOT_W];

    // a nonzero radicand is at least 2^16, so its root is never zero
    a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_root == '0) == out_zero))
        else $error("root and zero flag disagree");

endmodule

`default_nettype wire

// ----- design/tilt_cordic.sv -----
`default_nettype none

module tilt_cordic #(
    parameter int STAGES = tilt_pkg::CORDIC_STAGES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  tilt_pkg::cal_vec_t          in_cal,
    input  logic [tilt_pkg::ROOT_W-1:0] in_root,
    input  logic                        in_zero,
    output logic                        out_valid,
    output tilt_pkg::result_t           out_result
);

    localparam int N       = (STAGES > tilt_pkg::MAX_STAGES) ? tilt_pkg::MAX_STAGES : STAGES;
    localparam int CW      = tilt_pkg::CORDIC_W;
    localparam int AW      = tilt_pkg::ANGLE_W;
    localparam int TSUM_W  = AW + 1;
    localparam int DROP    = tilt_pkg::ANGLE_FRAC - tilt_pkg::TILT_FRAC;
    localparam int SHIFT_W = TSUM_W - DROP;
    localparam logic signed [TSUM_W-1:0] BIAS =
        TSUM_W'(tilt_pkg::DEG90_Q16 + tilt_pkg::TILT_ROUND);

    logic signed [CW-1:0]    x_reg     [0:N-2];
    logic signed [CW-1:0]    y_reg     [0:N-2];
    logic signed [AW-1:0]    z_reg     [0:N-1];
    tilt_pkg::cal_vec_t      cal_reg   [0:N-1];
    logic                    zero_reg  [0:N-1];
    logic                    valid_reg [0:N-1];

    logic signed [TSUM_W-1:0]    t;
    logic [SHIFT_W-1:0]          t_shift;
    logic [tilt_pkg::TILT_W-1:0] tilt_next;
    logic [tilt_pkg::TILT_W-1:0] tilt_reg;
    tilt_pkg::cal_vec_t          cal_out_reg;
    logic                        valid_out_reg;

    // vectoring rotations drive y toward zero, z collects the angle
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] STEP_ANGLE = AW'(tilt_pkg::ATAN_DEG_Q16[i]);

        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic signed [AW-1:0] z_prev;
        tilt_pkg::cal_vec_t   cal_prev;
        logic                 zero_prev;
        logic                 valid_prev;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [AW-1:0] z_next;

        if (i == 0)
        begin : g_first
            assign x_prev     = CW'(in_root);
            assign y_prev     = CW'(in_cal.cal_x) <<< tilt_pkg::Y_SCALE;
            assign z_prev     = '0;
            assign cal_prev   = in_cal;
            assign zero_prev  = in_zero;
            assign valid_prev = in_valid;
        end
        else
        begin : g_rest
            assign x_prev     = x_reg[i-1];
            assign y_prev     = y_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign cal_prev   = cal_reg[i-1];
            assign zero_prev  = zero_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        always_comb
        begin
            if (!y_prev[CW-1])
            begin
                x_next = x_prev + (y_prev >>> i);
                y_next = y_prev - (x_prev >>> i);
                z_next = z_prev + STEP_ANGLE;
            end
            else
            begin
                x_next = x_prev - (y_prev >>> i);
                y_next = y_prev + (x_prev >>> i);
                z_next = z_prev - STEP_ANGLE;
            end
        end

        // the last rotation only needs its angle
        if (i < N - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                z_reg[i]    <= z_next;
                cal_reg[i]  <= cal_prev;
                zero_reg[i] <= zero_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= valid_prev;
            end
        end
    end

    // shift by 90 degrees, round to q8.8, clamp; vertical vector handled apart
    always_comb
    begin
        t       = TSUM_W'(z_reg[N-1]) + BIAS;
        t_shift = t[TSUM_W-1:DROP];
        if (zero_reg[N-1])
        begin
            if (cal_reg[N-1].cal_x[tilt_pkg::SAMPLE_WIDTH-1])
            begin
                tilt_next = '0;
            end
            else if (cal_reg[N-1].cal_x != '0)
            begin
                tilt_next = tilt_pkg::TILT_MAX;
            end
            else
            begin
                tilt_next = tilt_pkg::TILT_MID;
            end
        end
        else if (t[TSUM_W-1])
        begin
            tilt_next = '0;
        end
        else if (t_shift > SHIFT_W'(tilt_pkg::TILT_MAX))
        begin
            tilt_next = tilt_pkg::TILT_MAX;
        end
        else
        begin
            tilt_next = t_shift[tilt_pkg::TILT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tilt_reg    <= tilt_next;
            cal_out_reg <= cal_reg[N-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_out_reg <= valid_reg[N-1];
        end
    end

    assign out_valid           = valid_out_reg;
    assign out_result.cal_x    = cal_out_reg.cal_x;
    assign out_result.cal_y    = cal_out_reg.cal_y;
    assign out_result.cal_z    = cal_out_reg.cal_z;
    assign out_result.tilt_deg = tilt_reg;

endmodule

`default_nettype wire

// ----- design/tilt_obuf.sv -----
`default_nettype none

module tilt_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tilt_pkg::result_t in_data,
    output logic              adv,
    output logic              result_valid,
    input  logic              result_stall,
    output tilt_pkg::result_t result
);

    localparam logic [1:0] BUF_DEPTH = 2'd2;

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    tilt_pkg::result_t head_reg;
    tilt_pkg::result_t head_next;
    tilt_pkg::result_t tail_reg;
    tilt_pkg::result_t tail_next;
    logic              push;
    logic              pop;

    // pipeline moves whenever a slot is free; taken from registered state only
    assign adv          = (count_reg != BUF_DEPTH);
    assign push         = adv && in_valid;
    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                head_next = in_data;
            end
            else
            begin
                tail_next = in_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign result = head_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BUF_DEPTH)
        else $error("output buffer overfilled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == 2'd1) |=> !result_valid)
        else $error("word repeated after last pop");

endmodule

`default_nettype wire

// ----- design/accel_calibrated_tilt_angle.sv -----
// Calibrated accelerometer tilt. Each sample word (raw x, y, z in milli-g) goes
// through a 3x3 Q2.14 gain matrix plus per-axis offsets, rounded half up and
// saturated to 16 bits, and then the tilt atan(x / sqrt(y^2 + z^2)) plus 90
// degrees is returned as unsigned Q8.8 (0 to 180 degrees) along with the three
// calibrated axes. A vector with y and z both zero reads 180, 0 or 90 degrees
// by the sign of x. The core is a fully pipelined datapath that takes one
// sample word every clock while the output buffer has a free entry: 2 stages
// of calibration (products, then sum and saturation), 2 stages of squaring
// and summing, 24 stages of square root at one root bit per stage,
// CORDIC_STAGES vectoring rotations (at most 24) and one stage of angle
// conversion, then a two-entry output buffer. The whole pipeline advances
// together while the output buffer has a free entry, so a sample is still
// taken while one finished result waits to be read.
// Coefficient rows are plain write-only registers, one per axis, reset to the
// identity matrix with zero offset; write them only while no samples are in
// flight.

`default_nettype none

module accel_calibrated_tilt_angle #(
    parameter int CORDIC_STAGES = tilt_pkg::CORDIC_STAGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  tilt_pkg::sample_t                sample,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output tilt_pkg::result_t                result,
    // coefficient write port
    input  logic                             cfg_write,
    input  logic [tilt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tilt_pkg::REG_W-1:0]       cfg_data
);

    // coefficient rows: gains in the low three fields, offset on top
    tilt_pkg::coeff_row_t rows_reg [tilt_pkg::NUM_AXES];

    // pipeline advance, shared by every stage
    logic adv;

    // calibration to magnitude
    logic                        calib_valid;
    tilt_pkg::cal_vec_t          calib_cal;

    // magnitude to cordic
    logic                        mag_valid;
    tilt_pkg::cal_vec_t          mag_cal;
    logic [tilt_pkg::ROOT_W-1:0] mag_root;
    logic                        mag_zero;

    // cordic to output buffer
    logic                        cordic_valid;
    tilt_pkg::result_t           cordic_result;

    // register writes; an index past the last row is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < tilt_pkg::NUM_AXES; a++)
            begin
                rows_reg[a] <= tilt_pkg::ROW_RESET[a];
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tilt_pkg::REG_ROW_X: rows_reg[tilt_pkg::AXIS_X] <= cfg_data;
                tilt_pkg::REG_ROW_Y: rows_reg[tilt_pkg::AXIS_Y] <= cfg_data;
                tilt_pkg::REG_ROW_Z: rows_reg[tilt_pkg::AXIS_Z] <= cfg_data;
                default: ;
            endcase
        end
    end

    // a sample word is taken whenever the pipeline moves
    assign sample_stall = !adv;

    // gain matrix, rounding, offset and saturation
    tilt_calib u_calib (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample_valid),
        .in_sample (sample),
        .rows      (rows_reg),
        .out_valid (calib_valid),
        .out_cal   (calib_cal)
    );

    // sqrt((y^2 + z^2) * 2^16), one root bit per stage
    tilt_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (calib_valid),
        .in_cal    (calib_cal),
        .out_valid (mag_valid),
        .out_cal   (mag_cal),
        .out_root  (mag_root),
        .out_zero  (mag_zero)
    );

    // unrolled vectoring cordic and conversion to q8.8 degrees
    tilt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (mag_valid),
        .in_cal     (mag_cal),
        .in_root    (mag_root),
        .in_zero    (mag_zero),
        .out_valid  (cordic_valid),
        .out_result (cordic_result)
    );

    // two-entry output buffer decouples the result stall from the pipeline
    tilt_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cordic_valid),
        .in_data      (cordic_result),
        .adv          (adv),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.tilt_deg <= tilt_pkg::TILT_MAX))
        else $error("tilt beyond 180 degrees");

endmodule

`default_nettype wire
